// ===== src/pctd_pkg.sv =====
// shared types and constants for the prefix code table decoder
package pctd_pkg;

   localparam int INDEX_W   = 6;
   localparam int SYMBOL_W  = 8;
   localparam int CODE_W    = 16;
   localparam int LENGTH_W  = 5;
   // compare width for code lengths, covers prefixes up to 63 bits
   localparam int LEN_CMP_W = 6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_BIT   = 1'b1;

   // table write broadcast to every cell
   typedef struct packed {
      logic                en;
      logic [INDEX_W-1:0]  index;
      logic [SYMBOL_W-1:0] symbol;
      logic [CODE_W-1:0]   code;
      logic [LENGTH_W-1:0] length;
   } wr_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                valid;
      logic                found;
      logic [SYMBOL_W-1:0] symbol;
   } scan_type;

endpackage

// ===== src/pctd_cell.sv =====
// one code table entry with its compare and the search token stage
module pctd_cell #(
   parameter int INDEX        = 0,
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pctd_pkg::wr_type            wr,
   input  logic [MAX_CODE_LEN-1:0]     prefix_bits,
   input  logic [pctd_pkg::LEN_CMP_W-1:0] prefix_len,
   input  pctd_pkg::scan_type          scan_prev,
   output pctd_pkg::scan_type          scan_next
);
   import pctd_pkg::*;

   logic [SYMBOL_W-1:0]     symbol_ff;
   logic [CODE_W-1:0]       code_ff;
   logic [LENGTH_W-1:0]     length_ff;
   logic [LENGTH_W-1:0]     length_in;
   logic                    sel;
   logic [MAX_CODE_LEN-1:0] code_ext;
   logic [MAX_CODE_LEN-1:0] len_mask;
   logic                    hit;
   scan_type                scan_ff;
   scan_type                scan_in;

   assign sel = wr.en && (int'(wr.index) == INDEX);

   assign length_in = sel ? wr.length : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         symbol_ff <= wr.symbol;
         code_ff   <= wr.code;
      end
   end

   // bits above the entry length are not compared
   assign code_ext = MAX_CODE_LEN'(code_ff);
   assign len_mask = ~({MAX_CODE_LEN{1'b1}} << length_ff);
   assign hit = (length_ff != '0) && (LEN_CMP_W'(length_ff) == prefix_len) &&
                ((code_ext & len_mask) == prefix_bits);

   // lowest index wins: an earlier hit passes through untouched
   always_comb begin
      scan_in = scan_prev;
      if (scan_prev.valid && !scan_prev.found && hit) begin
         scan_in.found  = 1'b1;
         scan_in.symbol = symbol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   assign scan_next = scan_ff;

endmodule

// ===== src/prefix_code_table_decoder.sv =====
// top level: prefix register, row of table cells and result register
// a table write takes effect at the accepting edge and leaves busy low
// a code bit shifts into the prefix and holds busy high while the search
// token walks the row of cells; the strobe, on a match or at MAX_CODE_LEN bits,
// comes in the first cycle with busy low, and no bit is accepted while busy
// synchronous reset empties every entry and clears the prefix
module prefix_code_table_decoder #(
   parameter int TABLE_DEPTH  = 64,
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic [pctd_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [pctd_pkg::SYMBOL_W-1:0]  req_entry_symbol,
   input  logic [pctd_pkg::CODE_W-1:0]    req_entry_code,
   input  logic [pctd_pkg::LENGTH_W-1:0]  req_entry_length,
   input  logic                           req_code_bit,
   output logic                           rsp_valid,
   output logic [pctd_pkg::SYMBOL_W-1:0]  rsp_symbol,
   output logic                           rsp_overflow
);
   import pctd_pkg::*;

   localparam int LW = $clog2(MAX_CODE_LEN + 1);

   logic                    accept;
   logic                    bit_go;
   logic                    done;
   logic                    emit;
   wr_type                  wr;
   logic [MAX_CODE_LEN-1:0] prefix_ff, prefix_in;
   logic [LW-1:0]           plen_ff, plen_in;
   logic                    launch_ff;
   logic                    busy_ff, busy_in;
   logic                    rsp_valid_ff;
   logic [SYMBOL_W-1:0]     rsp_symbol_ff;
   logic                    rsp_overflow_ff;
   scan_type                scan [TABLE_DEPTH+1];

   assign accept = start && !busy_ff;
   assign bit_go = accept && (req_op == OP_BIT);

   assign wr.en     = accept && (req_op == OP_WRITE);
   assign wr.index  = req_entry_index;
   assign wr.symbol = req_entry_symbol;
   assign wr.code   = req_entry_code;
   assign wr.length = req_entry_length;

   assign scan[0] = '{valid: launch_ff, found: 1'b0, symbol: '0};

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      pctd_cell #(
         .INDEX        (i),
         .MAX_CODE_LEN (MAX_CODE_LEN)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr          (wr),
         .prefix_bits (prefix_ff),
         .prefix_len  (LEN_CMP_W'(plen_ff)),
         .scan_prev   (scan[i]),
         .scan_next   (scan[i+1])
      );
   end

   assign done = scan[TABLE_DEPTH].valid;
   // a match beats overflow on the last allowed bit
   assign emit = done && (scan[TABLE_DEPTH].found || (plen_ff >= LW'(MAX_CODE_LEN)));

   always_comb begin
      prefix_in = prefix_ff;
      plen_in   = plen_ff;
      busy_in   = busy_ff;
      priority if (bit_go) begin
         prefix_in = {prefix_ff[MAX_CODE_LEN-2:0], req_code_bit};
         plen_in   = plen_ff + LW'(1);
         busy_in   = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
         if (emit) begin
            prefix_in = '0;
            plen_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= '0;
         plen_ff      <= '0;
         launch_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prefix_ff    <= prefix_in;
         plen_ff      <= plen_in;
         launch_ff    <= bit_go;
         busy_ff      <= busy_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_symbol_ff   <= scan[TABLE_DEPTH].found ? scan[TABLE_DEPTH].symbol : '0;
         rsp_overflow_ff <= !scan[TABLE_DEPTH].found;
      end
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_symbol   = rsp_symbol_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ===== src/pctd_checker.sv =====
// port level checks for the prefix code table decoder and their bind
module pctd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_op,
   input logic [pctd_pkg::INDEX_W-1:0]   req_entry_index,
   input logic [pctd_pkg::SYMBOL_W-1:0]  req_entry_symbol,
   input logic [pctd_pkg::CODE_W-1:0]    req_entry_code,
   input logic [pctd_pkg::LENGTH_W-1:0]  req_entry_length,
   input logic                           req_code_bit,
   input logic                           rsp_valid,
   input logic [pctd_pkg::SYMBOL_W-1:0]  rsp_symbol,
   input logic                           rsp_overflow
);
   import pctd_pkg::*;

   // a code bit always starts a search
   a_bit_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_BIT) |=> busy)
      else $error("code bit accepted without going busy");

   // a table write never yields a word
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_WRITE) |=> !busy && !rsp_valid)
      else $error("table write produced a word or went busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word while still searching");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word repeated");

   // overflow words carry a zero symbol
   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> (rsp_symbol == '0))
      else $error("overflow word with nonzero symbol");

endmodule

bind prefix_code_table_decoder pctd_checker u_pctd_checker (.*);
